// ===== src/sbcsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bus CSR package
// Shared types, constants and helpers of the CSR STATE and split-timeout block.
// ----------------------------------------------------------------------------
package sbcsr_pkg;

  localparam int unsigned OpW   = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned LoW   = 13;
  localparam int unsigned HiW   = 3;
  localparam int unsigned CycW  = 16;
  localparam int unsigned StW   = 3;

  localparam logic [DataW-1:0] CapsWord     = 32'h0000_83C0;
  localparam logic [LoW-1:0]   LoMin        = 13'd800;
  localparam logic [LoW-1:0]   LoMax        = 13'd7999;
  localparam logic [LoW-1:0]   LoReset      = 13'd800;
  localparam int unsigned      LoShift      = 19;
  localparam logic [CycW-1:0]  CyclesPerSec = 16'd8000;

  // Positions of the kept STATE bits in the packed state vector.
  localparam int unsigned StCmstr = 0;
  localparam int unsigned StAbd   = 1;
  localparam int unsigned StDreq  = 2;

  // Positions of the same bits in the STATE quadlet.
  localparam int unsigned QdCmstr = 8;
  localparam int unsigned QdAbd   = 10;
  localparam int unsigned QdDreq  = 14;

  typedef enum logic [OpW-1:0] {
    OpRdCaps   = 4'd0,
    OpRdState  = 4'd1,
    OpBitSet   = 4'd2,
    OpBitClr   = 4'd3,
    OpRdHi     = 4'd4,
    OpRdLo     = 4'd5,
    OpWrHi     = 4'd6,
    OpWrLo     = 4'd7,
    OpBusReset = 4'd8,
    OpReinit   = 4'd9,
    OpNop      = 4'd15
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [LoW-1:0] arg;
    logic           root;
    logic           cmc;
  } cmd_t;

  function automatic logic [DataW-1:0] state_word(input logic [StW-1:0] st);
    logic [DataW-1:0] w;
    w          = '0;
    w[QdCmstr] = st[StCmstr];
    w[QdAbd]   = st[StAbd];
    w[QdDreq]  = st[StDreq];
    return w;
  endfunction

  function automatic logic [CycW-1:0] split_cycles(input logic [HiW-1:0] hi,
                                                   input logic [LoW-1:0] lo);
    return CycW'(CycW'(hi) * CyclesPerSec) + CycW'(lo);
  endfunction

endpackage

// ===== src/sbcsr_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one register access transaction.
// ----------------------------------------------------------------------------
interface sbcsr_req_if;
  logic                      valid;
  logic                      ready;
  logic [sbcsr_pkg::OpW-1:0] opcode;
  logic [sbcsr_pkg::DataW-1:0] write_data;
  logic                      node_is_root;
  logic                      cycle_master_capable;

  modport source (output valid, opcode, write_data, node_is_root, cycle_master_capable,
                  input ready);
  modport sink (input valid, opcode, write_data, node_is_root, cycle_master_capable,
                output ready);
endinterface

// ===== src/sbcsr_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one access result transaction.
// ----------------------------------------------------------------------------
interface sbcsr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sbcsr_pkg::DataW-1:0]  read_data;
  logic [sbcsr_pkg::CycW-1:0]   split_timeout_cycles;
  logic                         cycle_master_on;
  logic                         cycle_master_off;

  modport source (output valid, read_data, split_timeout_cycles, cycle_master_on,
                  cycle_master_off, input ready);
  modport sink (input valid, read_data, split_timeout_cycles, cycle_master_on,
                cycle_master_off, output ready);
endinterface

// ===== src/sbcsr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSR front end
// Accepts access transactions and turns them into compact commands.
// ----------------------------------------------------------------------------
module sbcsr_front (
  sbcsr_req_if.sink          req_i,
  output sbcsr_pkg::cmd_t    cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i
);
  import sbcsr_pkg::*;

  logic [LoW-1:0] lo_raw;

  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;
  assign lo_raw      = req_i.write_data[DataW-1:LoShift];

  always_comb begin
    cmd_o      = '0;
    cmd_o.root = req_i.node_is_root;
    cmd_o.cmc  = req_i.cycle_master_capable;
    if (req_i.opcode <= OpW'(OpReinit)) begin
      cmd_o.op = op_e'(req_i.opcode);
    end else begin
      cmd_o.op = OpNop;
    end
    unique case (cmd_o.op)
      OpBitSet, OpBitClr: begin
        cmd_o.arg[StCmstr] = req_i.write_data[QdCmstr];
        cmd_o.arg[StAbd]   = req_i.write_data[QdAbd];
        cmd_o.arg[StDreq]  = req_i.write_data[QdDreq];
      end
      OpWrHi: begin
        cmd_o.arg[HiW-1:0] = req_i.write_data[HiW-1:0];
      end
      OpWrLo: begin
        if (lo_raw < LoMin) begin
          cmd_o.arg = LoMin;
        end else if (lo_raw > LoMax) begin
          cmd_o.arg = LoMax;
        end else begin
          cmd_o.arg = lo_raw;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/sbcsr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO that decouples the front end from the execute stage.
// ----------------------------------------------------------------------------
module sbcsr_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbcsr_pkg::cmd_t push_data_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output sbcsr_pkg::cmd_t pop_data_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);
  import sbcsr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/sbcsr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSR execute stage
// Holds the STATE and split-timeout registers, executes one command per cycle
// unless a held result is still waiting to be taken, and registers the result transaction.
// ----------------------------------------------------------------------------
module sbcsr_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [sbcsr_pkg::LoW-1:0] cfg_wdata_i,
  input  sbcsr_pkg::cmd_t          cmd_i,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  sbcsr_rsp_if.source              rsp_o
);
  import sbcsr_pkg::*;

  logic [StW-1:0]   st_q, st_d;
  logic [HiW-1:0]   hi_q, hi_d;
  logic [LoW-1:0]   lo_q, lo_d;
  logic             root_seen_q, root_seen_d;
  logic [LoW-1:0]   cfg_lo_q;
  logic             vld_q;
  logic [DataW-1:0] rd_q, rd_d;
  logic [CycW-1:0]  cyc_q;
  logic             on_q, on_d, off_q, off_d;
  logic             exec;

  assign cmd_ready_o = !vld_q || rsp_o.ready;
  assign exec        = cmd_valid_i && cmd_ready_o;

  assign rsp_o.valid                = vld_q;
  assign rsp_o.read_data            = rd_q;
  assign rsp_o.split_timeout_cycles = cyc_q;
  assign rsp_o.cycle_master_on      = on_q;
  assign rsp_o.cycle_master_off     = off_q;

  always_comb begin
    st_d        = st_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    root_seen_d = root_seen_q;
    rd_d        = '0;
    on_d        = 1'b0;
    off_d       = 1'b0;
    unique case (cmd_i.op)
      OpRdCaps:  rd_d = CapsWord;
      OpRdState: rd_d = state_word(st_q);
      OpBitSet: begin
        st_d = st_q | cmd_i.arg[StW-1:0];
        on_d = cmd_i.arg[StCmstr] && cmd_i.root;
      end
      OpBitClr: begin
        st_d  = st_q & ~cmd_i.arg[StW-1:0];
        off_d = cmd_i.arg[StCmstr] && cmd_i.root;
      end
      OpRdHi:    rd_d = DataW'(hi_q);
      OpRdLo:    rd_d = {lo_q, {LoShift{1'b0}}};
      OpWrHi:    hi_d = cmd_i.arg[HiW-1:0];
      OpWrLo:    lo_d = cmd_i.arg;
      OpBusReset: begin
        st_d[StAbd] = 1'b0;
        if (!cmd_i.root) begin
          root_seen_d   = 1'b0;
          st_d[StCmstr] = 1'b0;
        end else if (!root_seen_q) begin
          root_seen_d   = 1'b1;
          st_d[StCmstr] = cmd_i.cmc;
          on_d          = cmd_i.cmc;
          off_d         = !cmd_i.cmc;
        end
      end
      OpReinit: begin
        st_d        = '0;
        hi_d        = '0;
        lo_d        = cfg_lo_q;
        root_seen_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      hi_q        <= '0;
      lo_q        <= LoReset;
      root_seen_q <= 1'b0;
      cfg_lo_q    <= LoReset;
      vld_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_lo_q <= cfg_wdata_i;
      end
      if (exec) begin
        st_q        <= st_d;
        hi_q        <= hi_d;
        lo_q        <= lo_d;
        root_seen_q <= root_seen_d;
        vld_q       <= 1'b1;
      end else if (rsp_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rd_q  <= rd_d;
      cyc_q <= split_cycles(hi_d, lo_d);
      on_q  <= on_d;
      off_q <= off_d;
    end
  end

endmodule

// ===== src/serial_bus_csr_state_and_split_timeout_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bus CSR STATE and split-timeout block
// Top level: front end, command queue and execute stage.
// ----------------------------------------------------------------------------
// The block sustains one access transaction per clock cycle in both
// directions while every result is taken. A transaction is decoded in the
// front end on the cycle it is accepted, is written into a QueueDepth-entry
// command queue, and is then executed by the execute stage, which updates
// the registers and loads the result register; the result is held valid
// until it is taken. Requests are accepted while the queue has room, so a
// stalled response side is absorbed by QueueDepth plus one transactions.
// Write initial_split_lo only while no transaction is in flight.
module serial_bus_csr_state_and_split_timeout_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sbcsr_pkg::LoW-1:0] cfg_wdata_i,
  sbcsr_req_if.sink                 req_i,
  sbcsr_rsp_if.source               rsp_o
);
  import sbcsr_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  sbcsr_front u_front (
    .req_i       (req_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  sbcsr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  sbcsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .rsp_o       (rsp_o)
  );

`ifndef SYNTH
  a_on_off_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.cycle_master_on && rsp_o.cycle_master_off))
    else $error("cycle master on and off raised together");

  a_timeout_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.split_timeout_cycles <= 16'd64191))
    else $error("split timeout out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ready && !queue_valid) |=> !rsp_o.valid)
    else $error("result shown without a queued command");
`endif

endmodule
